// File: src/salc_pkg.sv
// Shared types, constants and default parameter values for the set-associative LRU cache model.
package salc_pkg;

    localparam int WAYS_DEF         = 4;
    localparam int MAX_SET_BITS_DEF = 6;
    localparam int AGE_WIDTH_DEF    = 16;

    localparam int ADDR_W     = 64;
    localparam int TAG_W      = 64;
    localparam int TOTAL_W    = 32;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam int SHIFT_W    = 7;

    typedef logic [1:0] t_func;

    localparam t_func FUNC_LOAD   = 2'd0;
    localparam t_func FUNC_STORE  = 2'd1;
    localparam t_func FUNC_MODIFY = 2'd2;
    localparam t_func FUNC_NONE   = 2'd3;

    // Register index, taken from the word address bit of paddr.
    localparam logic REG_SET_BITS   = 1'b0;
    localparam logic REG_BLOCK_BITS = 1'b1;

    localparam logic [2:0] SET_BITS_RESET   = 3'd4;
    localparam logic [5:0] BLOCK_BITS_RESET = 6'd4;

    typedef struct packed {
        logic [2:0] set_bits;
        logic [5:0] block_bits;
    } t_cfg;

    typedef struct packed {
        logic hit;
        logic miss;
        logic evict;
    } t_lookup;

endpackage

// File: src/salc_cfg.sv
// APB register file holding the set and block bit counts.
module salc_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [salc_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [salc_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [salc_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    output salc_pkg::t_cfg                   o_cfg
);
    import salc_pkg::*;

    t_cfg r_cfg;
    logic w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.set_bits   <= SET_BITS_RESET;
            r_cfg.block_bits <= BLOCK_BITS_RESET;
        end else if (w_wr) begin
            unique case (paddr[2])
                REG_SET_BITS:   r_cfg.set_bits   <= pwdata[2:0];
                REG_BLOCK_BITS: r_cfg.block_bits <= pwdata[5:0];
                default:        r_cfg            <= r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_SET_BITS:   prdata = {{(APB_DATA_W-3){1'b0}}, r_cfg.set_bits};
            REG_BLOCK_BITS: prdata = {{(APB_DATA_W-6){1'b0}}, r_cfg.block_bits};
            default:        prdata = '0;
        endcase
    end

endmodule

// File: src/salc_mem.sv
// Synchronous row memory holding the tags and ages of all ways of each set.
module salc_mem #(
    parameter int ADDR_BITS = 6,
    parameter int ROW_W     = 320
) (
    input  logic                 i_clk,
    input  logic                 i_rd_en,
    input  logic [ADDR_BITS-1:0] i_rd_addr,
    output logic [ROW_W-1:0]     o_rd_data,
    input  logic                 i_wr_en,
    input  logic [ADDR_BITS-1:0] i_wr_addr,
    input  logic [ROW_W-1:0]     i_wr_data
);
    localparam int DEPTH = 1 << ADDR_BITS;

    logic [ROW_W-1:0] r_mem [DEPTH];
    logic [ROW_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: src/salc_lookup.sv
// Tag compare, LRU aging and victim choice for one set row.
module salc_lookup #(
    parameter int WAYS      = 4,
    parameter int AGE_WIDTH = 16
) (
    input  logic [WAYS*(salc_pkg::TAG_W+AGE_WIDTH)-1:0] i_row,
    input  logic [WAYS-1:0]                             i_valid,
    input  logic [salc_pkg::TAG_W-1:0]                  i_tag,
    output logic [WAYS*(salc_pkg::TAG_W+AGE_WIDTH)-1:0] o_row,
    output logic [WAYS-1:0]                             o_valid,
    output salc_pkg::t_lookup                           o_flags
);
    import salc_pkg::*;

    localparam int LINE_W = TAG_W + AGE_WIDTH;
    localparam int WAY_IW = (WAYS > 1) ? $clog2(WAYS) : 1;

    logic [AGE_WIDTH-1:0] ages [WAYS];
    logic [TAG_W-1:0]     tags [WAYS];
    logic [AGE_WIDTH-1:0] best;
    logic [WAY_IW-1:0]    free_way;
    logic [WAY_IW-1:0]    victim;
    logic                 hit;
    logic                 have_free;

    always_comb begin
        hit       = 1'b0;
        have_free = 1'b0;
        free_way  = '0;
        victim    = '0;
        best      = '0;
        // Matching way goes young, the other valid ways age by one.
        for (int i = 0; i < WAYS; i++) begin
            tags[i] = i_row[i*LINE_W+AGE_WIDTH +: TAG_W];
            ages[i] = i_row[i*LINE_W +: AGE_WIDTH];
            if (i_valid[i] && (tags[i] == i_tag)) begin
                hit     = 1'b1;
                ages[i] = '0;
            end else if (i_valid[i]) begin
                if (ages[i] != {AGE_WIDTH{1'b1}}) begin
                    ages[i] = ages[i] + 1'b1;
                end
            end else begin
                have_free = 1'b1;
                free_way  = WAY_IW'(i);
            end
        end
        // A free way is taken first (the highest free one); else the oldest way wins and a tie goes to the higher way.
        if (have_free) begin
            victim = free_way;
        end else begin
            for (int i = 0; i < WAYS; i++) begin
                if (ages[i] >= best) begin
                    best   = ages[i];
                    victim = WAY_IW'(i);
                end
            end
        end
        o_valid = i_valid;
        if (!hit) begin
            tags[victim]    = i_tag;
            ages[victim]    = '0;
            o_valid[victim] = 1'b1;
        end
        for (int i = 0; i < WAYS; i++) begin
            o_row[i*LINE_W +: LINE_W] = {tags[i], ages[i]};
        end
        o_flags.hit   = hit;
        o_flags.miss  = !hit;
        o_flags.evict = !hit && !have_free;
    end

endmodule

// File: src/set_associative_lru_cache_model.sv
// Top level of the set-associative LRU cache model: control, valid bits and running totals.
//
//  Channel   | Handshake                          | Payload
//  ----------+------------------------------------+---------------------------------------
//  access in | i_in_valid / o_in_stall            | i_func, i_address
//  result    | o_out_valid / i_out_stall          | o_hits_added, o_was_miss,
//            |                                    | o_was_eviction, o_total_*
//  config    | psel, penable, pwrite, pready      | paddr, pwdata, prdata
//
// In the accept cycle of a transaction the set index and tag are
// formed and the set's row is read from the tag/age memory; in the lookup state that
// follows, the row is compared, aged and written back and the result register is loaded.
// The next transaction is accepted the cycle after that, so a following access to
// the same set reads the row already written back.
// If the previous result is still stalled, the lookup cycle waits for it to drain.
// Reset clears the valid bits and the totals at once; the memory is not cleared.
module set_associative_lru_cache_model #(
    parameter int WAYS         = salc_pkg::WAYS_DEF,
    parameter int MAX_SET_BITS = salc_pkg::MAX_SET_BITS_DEF,
    parameter int AGE_WIDTH    = salc_pkg::AGE_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [1:0]                        i_func,
    input  logic [salc_pkg::ADDR_W-1:0]       i_address,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [1:0]                        o_hits_added,
    output logic                              o_was_miss,
    output logic                              o_was_eviction,
    output logic [salc_pkg::TOTAL_W-1:0]      o_total_hits,
    output logic [salc_pkg::TOTAL_W-1:0]      o_total_misses,
    output logic [salc_pkg::TOTAL_W-1:0]      o_total_evictions,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [salc_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [salc_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [salc_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import salc_pkg::*;

    localparam int SET_IW = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int DEPTH  = 1 << SET_IW;
    localparam int LINE_W = TAG_W + AGE_WIDTH;
    localparam int ROW_W  = WAYS * LINE_W;

    // Control states: idle waits for an access, lookup works on the read row.
    localparam logic S_IDLE = 1'b0;
    localparam logic S_LOOK = 1'b1;

    t_cfg                w_cfg;
    logic                r_state;
    logic                n_state;
    logic [WAYS-1:0]     r_valid [DEPTH];
    logic [SET_IW-1:0]   r_set;
    logic [TAG_W-1:0]    r_tag;
    t_func               r_func;
    logic                r_out_valid;
    logic [1:0]          r_hits_added;
    logic                r_was_miss;
    logic                r_was_eviction;
    logic [TOTAL_W-1:0]  r_hit_total;
    logic [TOTAL_W-1:0]  r_miss_total;
    logic [TOTAL_W-1:0]  r_evict_total;
    logic [TOTAL_W-1:0]  n_hit_total;
    logic [TOTAL_W-1:0]  n_miss_total;
    logic [TOTAL_W-1:0]  n_evict_total;

    logic                w_accept;
    logic                w_done;
    logic                w_active;
    logic [SHIFT_W-1:0]  w_sb;
    logic [SHIFT_W-1:0]  w_tag_shift;
    logic [ADDR_W-1:0]   w_shifted;
    logic [SET_IW-1:0]   w_set;
    logic [TAG_W-1:0]    w_tag;
    logic [ROW_W-1:0]    w_rd_row;
    logic [ROW_W-1:0]    w_new_row;
    logic [WAYS-1:0]     w_new_valid;
    t_lookup             w_flags;
    logic [1:0]          w_hits_added;
    logic                w_miss;
    logic                w_evict;
    logic [TOTAL_W:0]    w_hit_sum;
    logic [TOTAL_W:0]    w_miss_sum;
    logic [TOTAL_W:0]    w_evict_sum;

    salc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // The block takes an access only when no lookup is in progress.
    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    // The lookup finishes once the result register is free or being emptied.
    assign w_done     = (r_state == S_LOOK) && (!r_out_valid || !i_out_stall);
    assign w_active   = (r_func != FUNC_NONE);

    // Address split. A set count above the memory's range acts as the largest one,
    // and a tag shift of 64 or more leaves a zero tag.
    always_comb begin
        if (int'(w_cfg.set_bits) > MAX_SET_BITS) begin
            w_sb = SHIFT_W'(MAX_SET_BITS);
        end else begin
            w_sb = SHIFT_W'(w_cfg.set_bits);
        end
        w_tag_shift = SHIFT_W'(w_cfg.block_bits) + w_sb;
        w_shifted   = i_address >> w_cfg.block_bits;
        for (int j = 0; j < SET_IW; j++) begin
            w_set[j] = w_shifted[j] && (SHIFT_W'(j) < w_sb);
        end
        if (w_tag_shift[SHIFT_W-1]) begin
            w_tag = '0;
        end else begin
            w_tag = i_address >> w_tag_shift[SHIFT_W-2:0];
        end
    end

    salc_mem #(
        .ADDR_BITS (SET_IW),
        .ROW_W     (ROW_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (w_accept),
        .i_rd_addr (w_set),
        .o_rd_data (w_rd_row),
        .i_wr_en   (w_done && w_active),
        .i_wr_addr (r_set),
        .i_wr_data (w_new_row)
    );

    salc_lookup #(
        .WAYS      (WAYS),
        .AGE_WIDTH (AGE_WIDTH)
    ) u_lookup (
        .i_row   (w_rd_row),
        .i_valid (r_valid[r_set]),
        .i_tag   (r_tag),
        .o_row   (w_new_row),
        .o_valid (w_new_valid),
        .o_flags (w_flags)
    );

    // The none operation leaves every count and line untouched.
    always_comb begin
        w_hits_added = '0;
        w_miss       = 1'b0;
        w_evict      = 1'b0;
        if (w_active) begin
            w_hits_added = 2'(w_flags.hit) + 2'(r_func == FUNC_MODIFY);
            w_miss       = w_flags.miss;
            w_evict      = w_flags.evict;
        end
        w_hit_sum     = {1'b0, r_hit_total} + (TOTAL_W+1)'(w_hits_added);
        w_miss_sum    = {1'b0, r_miss_total} + (TOTAL_W+1)'(w_miss);
        w_evict_sum   = {1'b0, r_evict_total} + (TOTAL_W+1)'(w_evict);
        n_hit_total   = w_hit_sum[TOTAL_W]   ? '1 : w_hit_sum[TOTAL_W-1:0];
        n_miss_total  = w_miss_sum[TOTAL_W]  ? '1 : w_miss_sum[TOTAL_W-1:0];
        n_evict_total = w_evict_sum[TOTAL_W] ? '1 : w_evict_sum[TOTAL_W-1:0];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_accept) n_state = S_LOOK;
            S_LOOK:  if (w_done) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_hit_total   <= '0;
            r_miss_total  <= '0;
            r_evict_total <= '0;
            for (int s = 0; s < DEPTH; s++) begin
                r_valid[s] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (w_done) begin
                r_out_valid   <= 1'b1;
                r_hit_total   <= n_hit_total;
                r_miss_total  <= n_miss_total;
                r_evict_total <= n_evict_total;
                if (w_active) begin
                    r_valid[r_set] <= w_new_valid;
                end
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Access payload and result flags carry no reset.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_set  <= w_set;
            r_tag  <= w_tag;
            r_func <= i_func;
        end
        if (w_done) begin
            r_hits_added   <= w_hits_added;
            r_was_miss     <= w_miss;
            r_was_eviction <= w_evict;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_hits_added      = r_hits_added;
    assign o_was_miss        = r_was_miss;
    assign o_was_eviction    = r_was_eviction;
    assign o_total_hits      = r_hit_total;
    assign o_total_misses    = r_miss_total;
    assign o_total_evictions = r_evict_total;

endmodule
